// File: rtl/core/jsbp_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsbp_pkg
// Shared types and constants for the json subset byte parser.
// ---------------------------------------------------------------------------
package jsbp_pkg;

    localparam int TEXT_CAPACITY_DEF = 16;

    localparam int BYTE_W   = 8;
    localparam int NUM_W    = 16;
    localparam int INDEX_W  = 4;
    localparam int RES_W    = 35;
    localparam int M_DATA_W = 40;

    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_QUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_T     = 8'h74;
    localparam logic [BYTE_W-1:0] CH_F     = 8'h66;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

    typedef enum logic [2:0] {
        ST_WAIT_BRACE = 3'd0,
        ST_WAIT_NAME  = 3'd1,
        ST_NAME       = 3'd2,
        ST_WAIT_VALUE = 3'd3,
        ST_INT        = 3'd4,
        ST_STR        = 3'd5
    } parse_state_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_NOT_JSON = 3'd1,
        EV_END      = 3'd2,
        EV_BOOL     = 3'd3,
        EV_INT      = 3'd4,
        EV_STR      = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        WT_NONE = 2'd0,
        WT_NAME = 2'd1,
        WT_STR  = 2'd2
    } write_target_t;

    // packed from msb down; event_res sits in the lowest bits
    typedef struct packed {
        logic [BYTE_W-1:0]  write_char;
        logic [INDEX_W-1:0] write_index;
        write_target_t      write_target;
        logic [NUM_W-1:0]   number_value;
        logic               flag_value;
        logic               busy_res;
        event_t             event_res;
    } result_t;

endpackage

// File: rtl/core/json_subset_byte_parser_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_subset_byte_parser_unit
// Byte-wide parser for a flat json subset, one result per received byte.
//
//   channel  dir  width  contents
//   s_*      in   8      rx_byte
//   m_*      out  40     event, busy, flag, number, write target/index/char
//
// each byte is accepted and its result is registered at the same
// edge, offered on m_* from the next cycle; a new byte can follow every cycle
// reset clears the parser state and the result valid flag
// a stalled result holds the input back only while m_tready is low
// ---------------------------------------------------------------------------
module json_subset_byte_parser_unit
    import jsbp_pkg::*;
#(
    parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,  // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    // [2:0] event_res, [3] busy_res, [4] flag_value, [20:5] number_value,
    // [22:21] write_target, [26:23] write_index, [34:27] write_char, rest zero
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int POS_W = $clog2(TEXT_CAPACITY);

    parse_state_t     state_reg;
    parse_state_t     state_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [NUM_W-1:0] acc_reg;
    logic [NUM_W-1:0] acc_next;
    logic             flag_reg;
    logic             flag_next;
    logic             busy_reg;
    logic             busy_next;
    result_t          res;
    logic             accept;

    assign accept = s_tvalid && s_tready;

    jsbp_step #(
        .TEXT_CAPACITY (TEXT_CAPACITY),
        .POS_W         (POS_W)
    ) u_step (
        .rx_byte    (s_tdata),
        .state      (state_reg),
        .pos        (pos_reg),
        .acc        (acc_reg),
        .flag       (flag_reg),
        .busy       (busy_reg),
        .state_next (state_next),
        .pos_next   (pos_next),
        .acc_next   (acc_next),
        .flag_next  (flag_next),
        .busy_next  (busy_next),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT_BRACE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            flag_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            flag_reg  <= flag_next;
            busy_reg  <= busy_next;
        end
    end

    jsbp_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .res      (res),
        .can_load (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/jsbp_step.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsbp_step
// Per-byte next-state and result logic of the parser.
// ---------------------------------------------------------------------------
module jsbp_step
    import jsbp_pkg::*;
#(
    parameter int TEXT_CAPACITY = TEXT_CAPACITY_DEF,
    parameter int POS_W         = $clog2(TEXT_CAPACITY)
)
(
    input  logic [BYTE_W-1:0] rx_byte,
    input  parse_state_t      state,
    input  logic [POS_W-1:0]  pos,
    input  logic [NUM_W-1:0]  acc,
    input  logic              flag,
    input  logic              busy,
    output parse_state_t      state_next,
    output logic [POS_W-1:0]  pos_next,
    output logic [NUM_W-1:0]  acc_next,
    output logic              flag_next,
    output logic              busy_next,
    output result_t           res
);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_CAPACITY - 2);

    logic [BYTE_W-1:0] digit;
    logic [NUM_W-1:0]  acc_x10;
    logic              is_digit;
    logic              can_store;
    event_t            ev;
    write_target_t     wt;

    assign digit     = rx_byte - CH_0;
    assign acc_x10   = (acc << 3) + (acc << 1);
    assign is_digit  = rx_byte inside {[CH_0:CH_9]};
    assign can_store = (pos <= POS_LAST);

    always_comb
    begin
        state_next = state;
        pos_next   = pos;
        acc_next   = acc;
        flag_next  = flag;
        busy_next  = busy;
        ev         = EV_NONE;
        wt         = WT_NONE;
        case (state)
            ST_WAIT_NAME:
            begin
                if (rx_byte == CH_CLOSE)
                begin
                    busy_next  = 1'b0;
                    state_next = ST_WAIT_BRACE;
                    ev         = EV_END;
                end
                else if (rx_byte == CH_QUOTE)
                begin
                    pos_next   = '0;
                    state_next = ST_NAME;
                end
            end
            ST_NAME:
            begin
                if (rx_byte == CH_QUOTE)
                begin
                    state_next = ST_WAIT_VALUE;
                end
                else if (can_store)
                begin
                    wt       = WT_NAME;
                    pos_next = pos + 1'b1;
                end
            end
            ST_WAIT_VALUE:
            begin
                if (rx_byte == CH_QUOTE)
                begin
                    pos_next   = '0;
                    state_next = ST_STR;
                end
                else if (rx_byte == CH_T || rx_byte == CH_F)
                begin
                    flag_next  = (rx_byte == CH_T);
                    state_next = ST_WAIT_NAME;
                    ev         = EV_BOOL;
                end
                else if (is_digit)
                begin
                    acc_next   = NUM_W'(digit);
                    state_next = ST_INT;
                end
            end
            ST_INT:
            begin
                if (is_digit)
                begin
                    acc_next = acc_x10 + NUM_W'(digit);
                end
                else
                begin
                    state_next = ST_WAIT_NAME;
                    ev         = EV_INT;
                end
            end
            ST_STR:
            begin
                if (rx_byte == CH_QUOTE)
                begin
                    state_next = ST_WAIT_NAME;
                    ev         = EV_STR;
                end
                else if (can_store)
                begin
                    wt       = WT_STR;
                    pos_next = pos + 1'b1;
                end
            end
            default:
            begin
                if (rx_byte == CH_OPEN)
                begin
                    busy_next  = 1'b1;
                    state_next = ST_WAIT_NAME;
                end
                else
                begin
                    state_next = ST_WAIT_BRACE;
                    ev         = EV_NOT_JSON;
                end
            end
        endcase
    end

    always_comb
    begin
        res.event_res    = ev;
        res.busy_res     = busy_next;
        res.flag_value   = flag_next;
        res.number_value = acc_next;
        res.write_target = wt;
        res.write_index  = (wt == WT_NONE) ? '0 : INDEX_W'(pos);
        res.write_char   = (wt == WT_NONE) ? '0 : rx_byte;
    end

endmodule

// File: rtl/core/jsbp_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jsbp_out_stage
// Result register with valid/ready hand-off to the output stream.
// ---------------------------------------------------------------------------
module jsbp_out_stage
    import jsbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  result_t             res,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_DATA_W - RES_W)'(0), res_reg};

endmodule
